// File: src/ilr_pkg.sv
// Shared types and constants for the indexed insert list with readout.
// No dependencies; imported by every module of the block.
`default_nettype none

package ilr_pkg;

    localparam int CapacityDefault = 16;
    localparam int QueueDepth      = 2;
    localparam int PosW            = 8;
    localparam int ValW            = 32;
    localparam int StW             = 2;

    typedef enum logic [StW-1:0] {
        ST_ELEM    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: src/ilr_front.sv
// Front end: accepts request beats, classifies them against a running count
// and pushes work items into the queue. Depends on ilr_pkg.
`default_nettype none

module ilr_front
    import ilr_pkg::*;
#(
    parameter int CAPACITY = CapacityDefault
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [PosW-1:0]             position,
    input  wire logic signed [ValW-1:0]      value,
    input  wire logic                        q_full,
    output logic                             q_push,
    output logic [StW+2*$clog2(CAPACITY)+ValW-1:0] q_data
);

    localparam int AddrW = $clog2(CAPACITY);
    localparam int CntW  = $clog2(CAPACITY + 1);

    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    status_t         status;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        priority if (position > PosW'(count_reg))
        begin
            status = ST_INVALID;
        end
        else if (count_reg == CntW'(CAPACITY))
        begin
            status = ST_FULL;
        end
        else
        begin
            status = ST_ELEM;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (q_push && status == ST_ELEM)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign q_data = {status, position[AddrW-1:0], count_reg[AddrW-1:0], value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/ilr_queue.sv
// Short register FIFO between front and back ends.
// Depends on ilr_pkg for its default depth.
`default_nettype none

module ilr_queue
    import ilr_pkg::*;
#(
    parameter int Width = 8,
    parameter int Depth = QueueDepth
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [Width-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [Width-1:0]      rd_data,
    output logic                  empty
);

    localparam int PtrW  = $clog2(Depth);
    localparam int FillW = $clog2(Depth + 1);

    logic [Width-1:0] slot_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [FillW-1:0] fill_reg;
    logic [FillW-1:0] fill_next;

    assign full    = fill_reg == FillW'(Depth);
    assign empty   = fill_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: src/ilr_back.sv
// Back end: holds the list memory, shifts and inserts, then streams the
// list forwards and backwards through a read stage and an output register;
// a status request answers with a single beat. Depends on ilr_pkg.
`default_nettype none

module ilr_back
    import ilr_pkg::*;
#(
    parameter int CAPACITY = CapacityDefault
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  wire logic [StW+2*$clog2(CAPACITY)+ValW-1:0] q_data,
    output logic                             q_pop,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic [StW-1:0]                   status,
    output logic                             direction,
    output logic signed [ValW-1:0]           element,
    output logic                             last
);

    localparam int AddrW = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_PUT   = 4'b0100,
        S_READ  = 4'b1000
    } back_state_t;

    status_t          q_status;
    logic [AddrW-1:0] q_pos;
    logic [AddrW-1:0] q_cnt;
    logic [ValW-1:0]  q_value;

    back_state_t      state_reg, state_next;
    logic [AddrW-1:0] pos_reg, pos_next;
    logic [AddrW-1:0] cnt_reg, cnt_next;
    logic [ValW-1:0]  val_reg, val_next;
    logic [AddrW-1:0] addr_reg, addr_next;
    logic             dir_reg, dir_next;
    logic             sh_pend_reg, sh_pend_next;
    logic [AddrW-1:0] sh_wa_reg, sh_wa_next;

    logic             r_vld_reg, r_vld_next;
    status_t          r_status_reg, r_status_next;
    logic             r_dir_reg, r_dir_next;
    logic             r_last_reg, r_last_next;
    logic [ValW-1:0]  rdata_reg;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg;
    logic             out_dir_reg;
    logic [ValW-1:0]  out_elem_reg;
    logic             out_last_reg;

    logic [ValW-1:0]  mem [CAPACITY];
    logic             mem_we;
    logic [AddrW-1:0] mem_wa;
    logic [ValW-1:0]  mem_wd;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             adv_o;
    logic             r_free;

    assign q_status = status_t'(q_data[StW+2*AddrW+ValW-1 -: StW]);
    assign {q_pos, q_cnt, q_value} = q_data[2*AddrW+ValW-1:0];

    assign adv_o  = !out_valid_reg || !rsp_stall;
    assign r_free = !r_vld_reg || adv_o;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        val_next      = val_reg;
        addr_next     = addr_reg;
        dir_next      = dir_reg;
        sh_pend_next  = sh_pend_reg;
        sh_wa_next    = sh_wa_reg;
        r_vld_next    = r_vld_reg;
        r_status_next = r_status_reg;
        r_dir_next    = r_dir_reg;
        r_last_next   = r_last_reg;
        out_valid_next = out_valid_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_wa        = sh_wa_reg;
        mem_wd        = rdata_reg;
        rd_en         = 1'b0;
        rd_addr       = addr_reg;

        if (adv_o)
        begin
            out_valid_next = r_vld_reg;
            r_vld_next     = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && !r_vld_reg)
                begin
                    q_pop = 1'b1;
                    if (q_status != ST_ELEM)
                    begin
                        r_vld_next    = 1'b1;
                        r_status_next = q_status;
                        r_dir_next    = 1'b0;
                        r_last_next   = 1'b1;
                    end
                    else
                    begin
                        pos_next     = q_pos;
                        cnt_next     = q_cnt;
                        val_next     = q_value;
                        sh_pend_next = 1'b0;
                        sh_wa_next   = q_cnt;
                        addr_next    = q_cnt - 1'b1;
                        state_next   = (q_cnt != q_pos) ? S_SHIFT : S_PUT;
                    end
                end
            end
            S_SHIFT:
            begin
                rd_en        = 1'b1;
                rd_addr      = addr_reg;
                sh_pend_next = 1'b1;
                sh_wa_next   = addr_reg + 1'b1;
                if (sh_pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (addr_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            S_PUT:
            begin
                mem_we = 1'b1;
                if (sh_pend_reg)
                begin
                    sh_pend_next = 1'b0;
                end
                else
                begin
                    mem_wa     = pos_reg;
                    mem_wd     = val_reg;
                    addr_next  = '0;
                    dir_next   = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (r_free)
                begin
                    rd_en         = 1'b1;
                    r_vld_next    = 1'b1;
                    r_status_next = ST_ELEM;
                    r_dir_next    = dir_reg;
                    r_last_next   = dir_reg && (addr_reg == '0);
                    if (!dir_reg)
                    begin
                        if (addr_reg == cnt_reg)
                        begin
                            dir_next = 1'b1;
                        end
                        else
                        begin
                            addr_next = addr_reg + 1'b1;
                        end
                    end
                    else if (addr_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next = addr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sh_pend_reg   <= 1'b0;
            r_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sh_pend_reg   <= sh_pend_next;
            r_vld_reg     <= r_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        addr_reg     <= addr_next;
        dir_reg      <= dir_next;
        sh_wa_reg    <= sh_wa_next;
        r_status_reg <= r_status_next;
        r_dir_reg    <= r_dir_next;
        r_last_reg   <= r_last_next;
        if (adv_o && r_vld_reg)
        begin
            out_status_reg <= r_status_reg;
            out_dir_reg    <= r_dir_reg;
            out_elem_reg   <= (r_status_reg == ST_ELEM) ? rdata_reg : '0;
            out_last_reg   <= r_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign direction = out_dir_reg;
    assign element   = out_elem_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

// File: src/indexed_insert_list_with_readout_unit.sv
// Top level of the indexed insert list with readout: front end, work queue
// and back end. Depends on ilr_pkg, ilr_front, ilr_queue and ilr_back.
//
// Keeps an ordered list of up to CAPACITY signed words. Each request inserts
// its value at the given position and answers with the whole list head to
// tail, then tail to head, with last on the final beat; a position beyond the
// count or a full list answers with a single status beat. The back end works
// on one request at a time through a list memory with one read and one write
// port: an insert at position p into a list that then holds n entries leaves
// the queue, moves the entries from p upwards up one place, finishes the last
// move and places the value (an append goes straight to placing it), then
// sends 2n response beats at one per cycle while rsp_stall is low, and the
// back end returns to idle before the next request leaves the queue. A status
// request is answered from the idle state without touching the list memory.
// The front end classifies requests and queues two ahead, so request beats
// are taken while the back end is still streaming.
`default_nettype none

module indexed_insert_list_with_readout_unit
    import ilr_pkg::*;
#(
    parameter int CAPACITY = CapacityDefault
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic [PosW-1:0]        position,
    input  wire logic signed [ValW-1:0] value,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output logic [StW-1:0]              status,
    output logic                        direction,
    output logic signed [ValW-1:0]      element,
    output logic                        last
);

    localparam int ItemW = StW + 2 * $clog2(CAPACITY) + ValW;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    logic [ItemW-1:0] q_wr_data;
    logic [ItemW-1:0] q_rd_data;

    ilr_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .position  (position),
        .value     (value),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    ilr_queue #(
        .Width (ItemW),
        .Depth (QueueDepth)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    ilr_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .direction (direction),
        .element   (element),
        .last      (last)
    );

endmodule

`default_nettype wire
